@@ rtl/f64cf_pkg.sv @@
package f64cf_pkg;

	localparam int unsigned SRC_W  = 64;
	localparam int unsigned MAN_W  = 52;
	localparam int unsigned EW_W   = 4;
	localparam int unsigned FW_W   = 6;
	localparam logic [10:0] DEXP_MAX = 11'h7FF;
	localparam int unsigned DBIAS  = 1023;

	// register indexes
	localparam logic CFG_EXPONENT_WIDTH = 1'b0;
	localparam logic CFG_FRACTION_WIDTH = 1'b1;

	typedef enum logic [1:0] {
		KIND_NUM,
		KIND_ZERO,
		KIND_INF,
		KIND_NAN
	} kind_t;

	// stage 1 to stage 2: classified and normalised operand
	typedef struct packed {
		logic        sign;
		kind_t       kind;
		logic [52:0] m53;
		logic [12:0] x;      // signed unbiased exponent
		logic [3:0]  ew;
		logic [5:0]  fw;
	} norm_t;

	// stage 2 to stage 3: shift decision
	typedef struct packed {
		logic        sign;
		kind_t       kind;
		logic        ovf;
		logic        sub;
		logic [12:0] eb;
		logic [52:0] q;
		logic        half;
		logic        sticky;
		logic [3:0]  ew;
		logic [5:0]  fw;
	} rnd_t;

endpackage

@@ rtl/f64cf_norm.sv @@
module f64cf_norm (
	input  logic [63:0]          src,
	input  logic [3:0]           ew_cfg,
	input  logic [5:0]           fw_cfg,
	output f64cf_pkg::norm_t     n
);
	logic [10:0] dexp;
	logic [51:0] dman;
	logic [5:0]  lz;
	logic [51:0] tmp;

	assign dexp = src[62:52];
	assign dman = src[51:0];

	// leading-zero count of the subnormal mantissa
	always_comb begin
		lz = 6'd0;
		tmp = dman;
		if (tmp[51:20] == 32'd0) begin lz = lz + 6'd32; tmp = tmp << 32; end
		if (tmp[51:36] == 16'd0) begin lz = lz + 6'd16; tmp = tmp << 16; end
		if (tmp[51:44] == 8'd0) begin lz = lz + 6'd8; tmp = tmp << 8; end
		if (tmp[51:48] == 4'd0) begin lz = lz + 6'd4; tmp = tmp << 4; end
		if (tmp[51:50] == 2'd0) begin lz = lz + 6'd2; tmp = tmp << 2; end
		if (tmp[51] == 1'b0) begin lz = lz + 6'd1; tmp = tmp << 1; end
	end

	always_comb begin
		n.sign = src[63];
		n.ew = (ew_cfg < 4'd2) ? 4'd2 : ((ew_cfg > 4'd11) ? 4'd11 : ew_cfg);
		n.fw = (fw_cfg < 6'd1) ? 6'd1 : ((fw_cfg > 6'd52) ? 6'd52 : fw_cfg);
		n.kind = f64cf_pkg::KIND_NUM;
		n.m53 = {1'b1, dman};
		n.x = 13'({2'b00, dexp}) - 13'(f64cf_pkg::DBIAS);
		if (dexp == f64cf_pkg::DEXP_MAX) begin
			n.kind = (dman != 52'd0) ? f64cf_pkg::KIND_NAN : f64cf_pkg::KIND_INF;
		end else if (dexp == 11'd0) begin
			if (dman == 52'd0) begin
				n.kind = f64cf_pkg::KIND_ZERO;
			end
			// t = 51 - lz, m53 = dman << (52 - t), x = -1074 + t
			n.m53 = {tmp, 1'b0};
			n.x = 13'(-1023) - 13'({7'd0, lz});
		end
	end
endmodule

@@ rtl/f64cf_shift.sv @@
module f64cf_shift (
	input  f64cf_pkg::norm_t n,
	output f64cf_pkg::rnd_t  r
);
	logic [12:0]  bias;
	logic [12:0]  expmax;
	logic [12:0]  eb;
	logic [13:0]  shw;
	logic [5:0]   sh;
	logic [105:0] wide;

	always_comb begin
		bias = (13'd1 << (n.ew - 4'd1)) - 13'd1;
		expmax = (13'd1 << n.ew) - 13'd1;
		eb = n.x + bias;
		r.sign = n.sign;
		r.kind = n.kind;
		r.ew = n.ew;
		r.fw = n.fw;
		r.eb = eb;
		r.ovf = ($signed(eb) >= $signed(expmax));
		r.sub = ($signed(eb) < 13'sd1);
		if (r.sub) begin
			shw = 14'd52 - 14'({8'd0, n.fw}) + 14'd1 - {eb[12], eb};
			sh = ($signed(shw) > 14'sd54) ? 6'd54 : shw[5:0];
		end else begin
			shw = 14'd52 - 14'({8'd0, n.fw});
			sh = shw[5:0];
		end
		wide = {n.m53, 53'd0} >> sh;
		r.q = wide[105:53];
		r.half = wide[52];
		r.sticky = |wide[51:0];
	end
endmodule

@@ rtl/f64cf_pack.sv @@
module f64cf_pack (
	input  f64cf_pkg::rnd_t r,
	output logic [63:0]     result,
	output logic            ovf
);
	logic [63:0] expmax;
	logic [63:0] inf_mag;
	logic [63:0] q;
	logic [63:0] mag;
	logic        up;

	always_comb begin
		expmax = (64'd1 << r.ew) - 64'd1;
		inf_mag = expmax << r.fw;
		up = r.half && (r.sticky || r.q[0]);
		q = {11'd0, r.q} + {63'd0, up};
		ovf = 1'b0;
		case (r.kind)
			f64cf_pkg::KIND_NAN: mag = inf_mag | (64'd1 << (r.fw - 6'd1));
			f64cf_pkg::KIND_INF: mag = inf_mag;
			f64cf_pkg::KIND_ZERO: mag = 64'd0;
			default: begin
				if (r.ovf) begin
					mag = inf_mag;
					ovf = 1'b1;
				end else if (!r.sub) begin
					mag = ({51'd0, r.eb - 13'd1} << r.fw) + q;
					if ((mag >> r.fw) >= expmax) begin
						mag = inf_mag;
						ovf = 1'b1;
					end
				end else begin
					mag = q;
				end
			end
		endcase
		result = ({63'd0, r.sign} << ({2'd0, r.ew} + r.fw)) | mag;
	end
endmodule

@@ rtl/float64_to_custom_float_core.sv @@
// an accepted item is registered in src_s1, norm_s2, rnd_s3 and res_s4 before output valid
// throughput: one item per cycle while the output is not stalled, stages are normalise, align/shift, round/pack
// a stalled output holds the pipeline; register contents are never lost
// reset: arst_n clears valid bits, exponent_width to 8, fraction_width to 23
module float64_to_custom_float_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // source_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // packed_result, overflow, zero fill
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);
	logic [3:0] ew_q;
	logic [5:0] fw_q;

	logic                 v_s1, v_s2, v_s3;
	logic [63:0]          src_s1;
	f64cf_pkg::norm_t     norm_c, norm_s2;
	f64cf_pkg::rnd_t      rnd_c, rnd_s3;
	logic [63:0]          res_c;
	logic                 ovf_c;
	logic [63:0]          res_s4;
	logic                 ovf_s4;
	logic                 v_s4;
	logic                 adv;

	// whole pipe moves together when the output slot is free or taken
	assign adv = !v_s4 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q <= 4'd8;
			fw_q <= 6'd23;
		end else if (cfg_we) begin
			if (cfg_index == f64cf_pkg::CFG_EXPONENT_WIDTH) ew_q <= cfg_data[3:0];
			else fw_q <= cfg_data;
		end
	end

	f64cf_norm u_norm (.src(src_s1), .ew_cfg(ew_q), .fw_cfg(fw_q), .n(norm_c));
	f64cf_shift u_shift (.n(norm_s2), .r(rnd_c));
	f64cf_pack u_pack (.r(rnd_s3), .result(res_c), .ovf(ovf_c));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1 <= s_axis_tdata;
			norm_s2 <= norm_c;
			rnd_s3 <= rnd_c;
			res_s4 <= res_c;
			ovf_s4 <= ovf_c;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = {7'd0, ovf_s4, res_s4};
endmodule
